>>> src/mep_pkg.sv
// Shared types and constants for the Mandelbrot escape-time pixel block.
package mep_pkg;

	localparam int FRAC_BITS  = 28;
	localparam int COUNT_BITS = 8;
	localparam int NUM_W      = 2 * COUNT_BITS;
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int NW         = FRAC_BITS + 5;
	localparam int MUL_LANES  = 3;
	localparam int ADDR_W     = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LEFT     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TOP      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COL_STEP = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ROW_STEP = 3'd4;

	localparam logic signed [NW-1:0] TWO  = NW'(64'd1 << (FRAC_BITS + 1));
	localparam logic signed [NW-1:0] FOUR = NW'(64'd1 << (FRAC_BITS + 2));

	typedef logic signed [MUL_W-1:0]  mul_op_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [NUM_W-1:0]         div_num_t;
	typedef logic [COUNT_BITS-1:0]    count_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_COORD,
		S_CPOINT,
		S_ADD,
		S_MUL,
		S_SEC,
		S_SEC_W,
		S_FRAC,
		S_FRAC_W
	} state_t;

endpackage

>>> src/mep_mul3.sv
// Three-lane signed multiplier with registered products, shared by the coordinate and iteration phases.
module mep_mul3 (
	input  logic            clk,
	input  logic            en,
	input  mep_pkg::mul_op_t op_a [mep_pkg::MUL_LANES],
	input  mep_pkg::mul_op_t op_b [mep_pkg::MUL_LANES],
	output mep_pkg::prod_t   prod [mep_pkg::MUL_LANES]
);
	import mep_pkg::*;

	prod_t prod_q [MUL_LANES];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < MUL_LANES; i++) begin
				prod_q[i] <= PROD_W'(op_a[i]) * PROD_W'(op_b[i]);
			end
		end
	end

	assign prod = prod_q;

endmodule

>>> src/mep_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module mep_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  mep_pkg::div_num_t    num,
	input  mep_pkg::count_t      den,
	output logic                 busy,
	output logic                 done,
	output mep_pkg::div_num_t    quo,
	output mep_pkg::count_t      rem
);
	import mep_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

	div_num_t         quo_q;
	count_t           rem_q;
	count_t           den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [COUNT_BITS:0]   shifted;
	logic [COUNT_BITS+1:0] diff;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[COUNT_BITS+1]) begin
				rem_q <= diff[COUNT_BITS-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[COUNT_BITS-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

>>> src/mandelbrot_escape_pixel.sv
// Mandelbrot escape-time pixel: sequencer, register file and hue colouring.
//
// Pulse start with busy low to hand in one pixel; busy stays high until the result beat,
// which sits on escape_count/red/green/blue for the single cycle that done is high and must
// be taken then. The point c is formed on the shared three-lane multiplier (multiply, then
// register c), then each z*z+c iteration runs on that same multiplier as add/check, then multiply. A
// point that never escapes gives its beat when the iteration count reaches limit; a point that
// escapes leaves the loop when a coordinate passes 2 or when the squared magnitude passes 4, and
// then makes two passes of the 16-step divider that works out the hue sector and channel
// fraction. No new pixel is taken while busy; register writes are meant for idle periods only.
module mandelbrot_escape_pixel #(
	parameter int COORD_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [COORD_BITS-1:0]         pixel_row,
	input  logic [COORD_BITS-1:0]         pixel_column,
	output logic                          done,
	output logic [mep_pkg::COUNT_BITS-1:0] escape_count,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mep_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import mep_pkg::*;

	localparam logic [2:0] SEC_R_UP   = 3'd0;
	localparam logic [2:0] SEC_G_FULL = 3'd1;
	localparam logic [2:0] SEC_B_UP   = 3'd2;
	localparam logic [2:0] SEC_B_FULL = 3'd3;
	localparam logic [2:0] SEC_R_RISE = 3'd4;

	state_t state_q, state_d;

	count_t              limit_q;
	logic signed [31:0]  left_q;
	logic signed [31:0]  top_q;
	logic [30:0]         cstep_q;
	logic [30:0]         rstep_q;

	logic [COORD_BITS-1:0] row_q, col_q;
	logic signed [NW-1:0]  cr_q, ci_q;
	mul_op_t               nr_q, ni_q;
	count_t                k_q, n_q;
	logic [2:0]            sector_q;
	count_t                frem_q;

	count_t     escape_count_q;
	logic [7:0] red_q, green_q, blue_q;
	logic       done_q;

	logic       cfg_wr;
	mul_op_t    op_a [MUL_LANES];
	mul_op_t    op_b [MUL_LANES];
	prod_t      prod [MUL_LANES];
	logic       mul_en;
	logic       div_start;
	div_num_t   div_num;
	logic       div_busy, div_done;
	div_num_t   div_quo;
	count_t     div_rem;

	prod_t                 sr_full, si_full, pm_full, re_sum, im_sum;
	logic signed [NW-1:0]  sr, si, pm, nr, ni, sq_sum;
	logic                  sum_esc, at_lim, bound_esc;
	count_t                fin_n;
	logic                  fin;
	logic [7:0]            t_val, q_val;

	function automatic logic signed [31:0] sat32(input prod_t v);
		logic hi_zero, hi_ones;
		hi_zero = (v[PROD_W-1:31] == '0);
		hi_ones = (v[PROD_W-1:31] == '1);
		if (hi_zero || hi_ones) begin
			sat32 = v[31:0];
		end else if (v[PROD_W-1]) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = 32'sh7FFF_FFFF;
		end
	endfunction

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= count_t'(80);
			left_q  <= -32'sd550292685;
			top_q   <= 32'sd335544320;
			cstep_q <= 31'd187904;
			rstep_q <= 31'd223696;
		end else if (cfg_wr) begin
			case (paddr[ADDR_W-1:2])
				REG_LIMIT:    limit_q <= pwdata[COUNT_BITS-1:0];
				REG_LEFT:     left_q  <= pwdata;
				REG_TOP:      top_q   <= pwdata;
				REG_COL_STEP: cstep_q <= pwdata[30:0];
				REG_ROW_STEP: rstep_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_LIMIT:    prdata = {{(32-COUNT_BITS){1'b0}}, limit_q};
			REG_LEFT:     prdata = left_q;
			REG_TOP:      prdata = top_q;
			REG_COL_STEP: prdata = {1'b0, cstep_q};
			REG_ROW_STEP: prdata = {1'b0, rstep_q};
			default:      prdata = '0;
		endcase
	end

	// shared multiplier
	always_comb begin
		if (state_q == S_COORD) begin
			op_a[0] = {{(MUL_W-COORD_BITS){1'b0}}, col_q};
			op_b[0] = {1'b0, cstep_q};
			op_a[1] = {{(MUL_W-COORD_BITS){1'b0}}, row_q};
			op_b[1] = {1'b0, rstep_q};
			op_a[2] = '0;
			op_b[2] = '0;
		end else begin
			op_a[0] = nr_q;
			op_b[0] = nr_q;
			op_a[1] = ni_q;
			op_b[1] = ni_q;
			op_a[2] = nr_q;
			op_b[2] = ni_q;
		end
	end

	mep_mul3 u_mul (
		.clk  (clk),
		.en   (mul_en),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	// iteration datapath; products are truncated toward minus infinity
	assign re_sum  = {{(PROD_W-32){left_q[31]}}, left_q} + prod[0];
	assign im_sum  = {{(PROD_W-32){top_q[31]}}, top_q} - prod[1];
	assign sr_full = prod[0] >>> FRAC_BITS;
	assign si_full = prod[1] >>> FRAC_BITS;
	assign pm_full = prod[2] >>> (FRAC_BITS - 1);
	assign sr      = (k_q == '0) ? '0 : sr_full[NW-1:0];
	assign si      = (k_q == '0) ? '0 : si_full[NW-1:0];
	assign pm      = (k_q == '0) ? '0 : pm_full[NW-1:0];
	assign nr      = sr - si + cr_q;
	assign ni      = pm + ci_q;
	assign sq_sum  = sr + si;

	assign sum_esc   = (k_q != '0) && (sq_sum > FOUR);
	assign at_lim    = (k_q == limit_q);
	assign bound_esc = (nr > TWO) || (nr < -TWO) || (ni > TWO) || (ni < -TWO);
	assign fin       = sum_esc || at_lim || bound_esc;

	always_comb begin
		if (sum_esc) begin
			fin_n = k_q - 1'b1;
		end else if (at_lim) begin
			fin_n = limit_q;
		end else begin
			fin_n = k_q;
		end
	end

	// hue division
	assign div_num = (state_q == S_SEC) ?
		(({{COUNT_BITS{1'b0}}, n_q} << 2) + ({{COUNT_BITS{1'b0}}, n_q} << 1)) :
		({frem_q, {COUNT_BITS{1'b0}}} - {{COUNT_BITS{1'b0}}, frem_q});

	mep_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (limit_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	assign t_val = div_quo[7:0];
	assign q_val = 8'd255 - t_val - {7'd0, (div_rem != '0)};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_en    = 1'b0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_COORD;
			end
			S_COORD: begin
				mul_en  = 1'b1;
				state_d = S_CPOINT;
			end
			S_CPOINT: state_d = S_ADD;
			S_ADD: begin
				if (!fin) begin
					state_d = S_MUL;
				end else if (fin_n == limit_q) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_SEC;
				end
			end
			S_MUL: begin
				mul_en  = 1'b1;
				state_d = S_ADD;
			end
			S_SEC: begin
				div_start = 1'b1;
				state_d   = S_SEC_W;
			end
			S_SEC_W: begin
				if (div_done) state_d = S_FRAC;
			end
			S_FRAC: begin
				div_start = 1'b1;
				state_d   = S_FRAC_W;
			end
			S_FRAC_W: begin
				if (div_done) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((state_q == S_ADD) && fin && (fin_n == limit_q)) ||
			          ((state_q == S_FRAC_W) && div_done);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				row_q <= pixel_row;
				col_q <= pixel_column;
			end
			S_CPOINT: begin
				cr_q <= NW'(sat32(re_sum));
				ci_q <= NW'(sat32(im_sum));
				k_q  <= '0;
			end
			S_ADD: begin
				nr_q <= nr[MUL_W-1:0];
				ni_q <= ni[MUL_W-1:0];
				n_q  <= fin_n;
				if (fin && (fin_n == limit_q)) begin
					escape_count_q <= fin_n;
					red_q          <= '0;
					green_q        <= '0;
					blue_q         <= '0;
				end
			end
			S_MUL: k_q <= k_q + 1'b1;
			S_SEC_W: begin
				if (div_done) begin
					sector_q <= div_quo[2:0];
					frem_q   <= div_rem;
				end
			end
			S_FRAC_W: begin
				if (div_done) begin
					escape_count_q <= n_q;
					case (sector_q)
						SEC_R_UP: begin
							red_q <= 8'd255; green_q <= t_val;  blue_q <= 8'd0;
						end
						SEC_G_FULL: begin
							red_q <= q_val;  green_q <= 8'd255; blue_q <= 8'd0;
						end
						SEC_B_UP: begin
							red_q <= 8'd0;   green_q <= 8'd255; blue_q <= t_val;
						end
						SEC_B_FULL: begin
							red_q <= 8'd0;   green_q <= q_val;  blue_q <= 8'd255;
						end
						SEC_R_RISE: begin
							red_q <= t_val;  green_q <= 8'd0;   blue_q <= 8'd255;
						end
						default: begin
							red_q <= 8'd255; green_q <= 8'd0;   blue_q <= q_val;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign escape_count = escape_count_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;

	// checks
	a_end_with_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result beat");

	a_hue_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (red == 8'd255 || green == 8'd255 || blue == 8'd255 ||
		          (red == 8'd0 && green == 8'd0 && blue == 8'd0)))
		else $error("colour is neither a full-saturation hue nor black");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == S_SEC_W || state_q == S_FRAC_W))
		else $error("divider running outside a wait state");

endmodule

>>> bench/mandelbrot_escape_pixel_checker.sv
`timescale 1ns / 100ps
// Result checker for the Mandelbrot pixel block: register mirror, pixel predictor, beat compare.
module mandelbrot_escape_pixel_checker #(
	parameter int COORD_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [COORD_BITS-1:0]          pixel_row,
	input  logic [COORD_BITS-1:0]          pixel_column,
	input  logic                           done,
	input  logic [mep_pkg::COUNT_BITS-1:0] escape_count,
	input  logic [7:0]                     red,
	input  logic [7:0]                     green,
	input  logic [7:0]                     blue,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [mep_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                    pwdata,
	output int                             failures,
	output int                             outstanding,
	output int                             results_seen
);
	import mep_pkg::*;

	typedef struct packed {
		count_t     count;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} shade_t;

	localparam longint Q28_MAX = 64'sd2147483647;
	localparam longint Q28_MIN = -64'sd2147483648;

	count_t              limit_q;
	longint              left_q;
	longint              top_q;
	longint              col_step_q;
	longint              row_step_q;
	shade_t              pending_shades[$];
	shade_t              got;
	shade_t              want;
	logic [REG_IDX_W-1:0] reg_idx;
	int                  mismatches;
	int                  n_results;

	function automatic longint clamp_q28(input longint v);
		if (v > Q28_MAX)
			return Q28_MAX;
		if (v < Q28_MIN)
			return Q28_MIN;
		return v;
	endfunction

	// Q4.28 to the iterate format, flooring when bits are dropped
	function automatic longint rescale(input longint v);
		if (FRAC_BITS >= 28)
			return v <<< (FRAC_BITS - 28);
		return v >>> (28 - FRAC_BITS);
	endfunction

	function automatic longint mul_floor(input longint a, input longint b, input int s);
		logic signed [127:0] wa;
		logic signed [127:0] wb;
		logic signed [127:0] p;
		wa = a;
		wb = b;
		p = (wa * wb) >>> s;
		return p[63:0];
	endfunction

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic shade_t shade_pixel(input logic [COORD_BITS-1:0] row,
			input logic [COORD_BITS-1:0] col);
		longint      cr, ci, zr, zi, sr, si, nr, ni, two, four;
		int unsigned lim, n, k, six, sector, rest, t, q;
		logic        escaped;
		shade_t      px;
		cr = rescale(clamp_q28(left_q + longint'(col) * col_step_q));
		ci = rescale(clamp_q28(top_q - longint'(row) * row_step_q));
		two = 64'sd1 <<< (FRAC_BITS + 1);
		four = 64'sd1 <<< (FRAC_BITS + 2);
		zr = 0;
		zi = 0;
		sr = 0;
		si = 0;
		lim = limit_q;
		n = lim;
		escaped = 1'b0;
		for (k = 0; k < lim && !escaped; k++) begin
			nr = sr - si + cr;
			ni = mul_floor(zr, zi, FRAC_BITS - 1) + ci;
			if (mag(nr) > two || mag(ni) > two) begin
				n = k;
				escaped = 1'b1;
			end else begin
				sr = mul_floor(nr, nr, FRAC_BITS);
				si = mul_floor(ni, ni, FRAC_BITS);
				if (sr + si > four) begin
					n = k;
					escaped = 1'b1;
				end else begin
					zr = nr;
					zi = ni;
				end
			end
		end
		px = '0;
		px.count = count_t'(n);
		// hue over six sectors; points inside the set stay black
		if (n < lim) begin
			six = 6 * n;
			sector = six / lim;
			rest = six % lim;
			t = (255 * rest) / lim;
			q = (255 * (lim - rest)) / lim;
			case (sector)
				0: begin
					px.red = 8'd255; px.green = t[7:0];  px.blue = 8'd0;
				end
				1: begin
					px.red = q[7:0]; px.green = 8'd255;  px.blue = 8'd0;
				end
				2: begin
					px.red = 8'd0;   px.green = 8'd255;  px.blue = t[7:0];
				end
				3: begin
					px.red = 8'd0;   px.green = q[7:0];  px.blue = 8'd255;
				end
				4: begin
					px.red = t[7:0]; px.green = 8'd0;    px.blue = 8'd255;
				end
				default: begin
					px.red = 8'd255; px.green = 8'd0;    px.blue = q[7:0];
				end
			endcase
		end
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q = count_t'(80);
			left_q = -64'sd550292685;
			top_q = 64'sd335544320;
			col_step_q = 64'sd187904;
			row_step_q = 64'sd223696;
			pending_shades.delete();
			mismatches = 0;
			n_results = 0;
			failures <= 0;
			outstanding <= 0;
			results_seen <= 0;
		end else begin
			if (done) begin
				got = {escape_count, red, green, blue};
				n_results++;
				if (pending_shades.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result beat with nothing expected: count %0d rgb %0d/%0d/%0d",
							$realtime, got.count, got.red, got.green, got.blue);
				end else begin
					want = pending_shades.pop_front();
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: beat %0d expected count %0d rgb %0d/%0d/%0d, got count %0d rgb %0d/%0d/%0d",
								$realtime, n_results, want.count, want.red, want.green, want.blue,
								got.count, got.red, got.green, got.blue);
					end
				end
			end
			if (start && !busy)
				pending_shades.push_back(shade_pixel(pixel_row, pixel_column));
			if (psel && penable && pwrite && pready) begin
				reg_idx = paddr[ADDR_W-1:2];
				case (reg_idx)
					REG_LIMIT:    limit_q = pwdata[COUNT_BITS-1:0];
					REG_LEFT:     left_q = longint'(signed'(pwdata));
					REG_TOP:      top_q = longint'(signed'(pwdata));
					REG_COL_STEP: col_step_q = longint'({1'b0, pwdata[30:0]});
					REG_ROW_STEP: row_step_q = longint'({1'b0, pwdata[30:0]});
					default: ;
				endcase
			end
			failures <= mismatches;
			outstanding <= pending_shades.size();
			results_seen <= n_results;
		end
	end

endmodule

>>> bench/mandelbrot_escape_pixel_tb.sv
`timescale 1ns / 100ps
// Testbench top for the Mandelbrot pixel block: clock, reset, pixel and register stimulus, verdict.
module mandelbrot_escape_pixel_tb;
	import mep_pkg::*;

	localparam int COORD_BITS    = 12;
	localparam int IDLE_LIMIT    = 20000;
	localparam int DRAIN_CYCLES  = 600;
	localparam int RANDOM_PIXELS = 500;

	localparam logic [31:0] DEF_LEFT     = 32'hDF333333;
	localparam logic [31:0] DEF_TOP      = 32'd335544320;
	localparam logic [31:0] DEF_COL_STEP = 32'd187904;
	localparam logic [31:0] DEF_ROW_STEP = 32'd223696;
	localparam logic [31:0] Q28_TOP      = 32'h7FFFFFFF;
	localparam logic [31:0] Q28_BOTTOM   = 32'h80000000;

	localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [COORD_BITS-1:0]   pixel_row;
	logic [COORD_BITS-1:0]   pixel_column;
	logic                    done;
	logic [COUNT_BITS-1:0]   escape_count;
	logic [7:0]              red;
	logic [7:0]              green;
	logic [7:0]              blue;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [31:0]             pwdata;
	logic [31:0]             prdata;
	logic                    pready;

	int failures;
	int outstanding;
	int results_seen;
	int idle_cycles = 0;
	int burst_left = 0;
	int pixels_sent = 0;
	int directed_sent = 0;
	int reg_writes = 0;
	int settings_used = 1;

	always #5 clk = ~clk;

	mandelbrot_escape_pixel #(.COORD_BITS(COORD_BITS)) DUT (.*);

	mandelbrot_escape_pixel_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);

	// ends the run when neither channel nor the register port moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable && pwrite && pready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d results outstanding",
				$realtime, IDLE_LIMIT, outstanding);
			$display("FAILED: results differ");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic load_window(input logic [7:0] limit, input logic [31:0] left,
			input logic [31:0] top, input logic [31:0] col_step, input logic [31:0] row_step);
		write_reg(REG_LIMIT, {24'd0, limit});
		write_reg(REG_LEFT, left);
		write_reg(REG_TOP, top);
		write_reg(REG_COL_STEP, col_step);
		write_reg(REG_ROW_STEP, row_step);
		settings_used++;
	endtask

	// one input beat; bursts keep start high, otherwise a random gap follows
	task automatic send_pixel(input logic [COORD_BITS-1:0] row, input logic [COORD_BITS-1:0] col);
		int gap;
		start <= 1'b1;
		pixel_row <= row;
		pixel_column <= col;
		do @(posedge clk); while (busy);
		pixels_sent++;
		if (burst_left > 0)
			burst_left--;
		else begin
			start <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 5);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0 || busy);
	endtask

	initial begin
		int n_items;
		logic [7:0] limit;
		arst_n <= 1'b0;
		start <= 1'b0;
		pixel_row <= '0;
		pixel_column <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window: corners, the centre and a point inside the set
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd1500, 12'd2930);
		settle();

		// coordinates pushed past the Q4.28 range in both directions
		load_window(8'd255, Q28_TOP, Q28_BOTTOM, Q28_TOP, Q28_TOP);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		settle();

		// zero limit, plus writes to unmapped addresses that must change nothing
		load_window(8'd0, DEF_LEFT, DEF_TOP, DEF_COL_STEP, DEF_ROW_STEP);
		for (int idx = REG_SPARE_FIRST; idx <= REG_SPARE_LAST; idx++)
			write_reg(REG_IDX_W'(idx), $urandom);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1500, 12'd2930);
		settle();

		load_window(8'd1, DEF_LEFT, DEF_TOP, DEF_COL_STEP, DEF_ROW_STEP);
		send_pixel(12'd1500, 12'd2930);
		send_pixel(12'd0, 12'd0);
		settle();

		load_window(8'd255, DEF_LEFT, DEF_TOP, DEF_COL_STEP, DEF_ROW_STEP);
		send_pixel(12'd1500, 12'd2930);
		send_pixel(12'd1200, 12'd2200);
		send_pixel(12'd4095, 12'd4095);
		settle();
		directed_sent = pixels_sent;

		while (pixels_sent - directed_sent < RANDOM_PIXELS) begin
			case ($urandom_range(0, 9))
				0:       limit = 8'd255;
				1:       limit = 8'd1;
				2, 3:    limit = 8'($urandom_range(1, 255));
				default: limit = 8'($urandom_range(2, 48));
			endcase
			if ($urandom_range(0, 4) == 0)
				load_window(limit, $urandom, $urandom, $urandom, $urandom);
			else
				load_window(limit, int'($urandom_range(0, 805306368)) - 671088640,
					int'($urandom_range(0, 456340275)) - 53687091,
					$urandom_range(16384, 262144), $urandom_range(16384, 262144));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
					$urandom);
			n_items = $urandom_range(30, 70);
			repeat (n_items)
				send_pixel(COORD_BITS'($urandom_range(0, 4095)),
					COORD_BITS'($urandom_range(0, 4095)));
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d pixels (%0d directed) under %0d register settings, %0d register writes.",
			pixels_sent, directed_sent, settings_used, reg_writes);
		$display("Checked %0d result beats; %0d mismatched, %0d never arrived.",
			results_seen, failures, outstanding);
		if (failures == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
src/mep_pkg.sv
src/mep_mul3.sv
src/mep_div.sv
src/mandelbrot_escape_pixel.sv
bench/mandelbrot_escape_pixel_checker.sv
bench/mandelbrot_escape_pixel_tb.sv
